### hdl/psp_pkg.sv
// psp_pkg: shared types and constants of the PGM stream parser.
// Beat structs for both channels, result/error codes, character codes.
// No dependencies.
`default_nettype none

package psp_pkg;

	localparam int COORD_BITS = 16;
	localparam logic [19:0] COORD_MAX = 20'((1 << COORD_BITS) - 1);
	localparam logic [19:0] SAMPLE_MAX = 20'd65535;
	localparam logic [15:0] TWO_BYTE_MIN = 16'd256;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_2 = 8'h32;
	localparam logic [7:0] CH_5 = 8'h35;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_ERROR = 2'd2,
		KIND_DONE = 2'd3
	} kind_e;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_BAD_MAGIC = 3'd1,
		ERR_DIGIT = 3'd2,
		ERR_OVERFLOW = 3'd3,
		ERR_NO_SEP = 3'd4,
		ERR_ABOVE_MAX = 3'd5,
		ERR_TRUNCATED = 3'd6
	} err_e;

	typedef struct packed {
		logic [7:0] byte_value;
		logic end_of_file;
	} stream_beat_t;

	typedef struct packed {
		kind_e kind;
		logic [15:0] pixel_value;
		logic [15:0] column;
		logic [15:0] row;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [15:0] max_value;
		err_e error_code;
		logic trailing_data;
		logic last;
	} result_beat_t;

endpackage

`default_nettype wire

### hdl/psp_parser.sv
// psp_parser: parse state of the PGM stream and the per-byte step logic.
// One byte per enabled cycle; produces zero, one or two result beats.
// Depends on psp_pkg.
`default_nettype none

module psp_parser import psp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire stream_beat_t beat,
	output logic [1:0] res_count,
	output result_beat_t res0,
	output result_beat_t res1
);

	typedef enum logic [2:0] {
		PH_MAGIC_P,
		PH_MAGIC_D,
		PH_HDR_W,
		PH_HDR_H,
		PH_HDR_M,
		PH_PIX,
		PH_TRAIL
	} phase_e;

	typedef struct packed {
		phase_e phase;
		logic binary_format;
		logic two_byte;
		logic in_comment;
		logic [15:0] acc;
		logic digit_seen;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] maxval;
		logic [15:0] col;
		logic [15:0] row;
		logic [7:0] high_byte;
		logic high_held;
		logic err_latched;
		logic trailing;
	} state_t;

	typedef struct packed {
		err_e err;
		state_t s;
	} idle_t;

	typedef struct packed {
		logic ok;
		logic [15:0] col;
		logic [15:0] row;
		state_t s;
	} put_t;

	localparam state_t ST_RESET = '{
		phase: PH_MAGIC_P, binary_format: 1'b0, two_byte: 1'b0, in_comment: 1'b0,
		acc: 16'd0, digit_seen: 1'b0, width: 16'd0, height: 16'd0, maxval: 16'd0,
		col: 16'd0, row: 16'd0, high_byte: 8'd0, high_held: 1'b0,
		err_latched: 1'b0, trailing: 1'b0
	};

	function automatic logic is_ws(input logic [7:0] b);
		return b inside {CH_SP, CH_TAB, CH_CR, CH_LF};
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[CH_0:CH_9]};
	endfunction

	function automatic logic [15:0] digit_of(input logic [7:0] b);
		logic [7:0] d;
		d = b - CH_0;
		return {12'd0, d[3:0]};
	endfunction

	// whitespace / comment skip ahead of a header number
	function automatic idle_t hdr_idle(input state_t s, input logic [7:0] b);
		idle_t r;
		r.err = ERR_NONE;
		r.s = s;
		if (s.in_comment) begin
			if (b == CH_CR || b == CH_LF)
				r.s.in_comment = 1'b0;
		end else if (is_ws(b)) begin
			r.s = s;
		end else if (b == CH_HASH) begin
			r.s.in_comment = 1'b1;
		end else if (is_digit(b)) begin
			r.s.digit_seen = 1'b1;
			r.s.acc = digit_of(b);
		end else begin
			r.err = ERR_DIGIT;
		end
		return r;
	endfunction

	function automatic idle_t pix_idle(input state_t s, input logic [7:0] b);
		idle_t r;
		r.err = ERR_NONE;
		r.s = s;
		if (is_digit(b)) begin
			r.s.digit_seen = 1'b1;
			r.s.acc = digit_of(b);
		end else if (!is_ws(b)) begin
			r.err = ERR_DIGIT;
		end
		return r;
	endfunction

	function automatic state_t trail_fn(input state_t s, input logic [7:0] b);
		state_t r;
		r = s;
		if (s.in_comment) begin
			if (b == CH_CR || b == CH_LF)
				r.in_comment = 1'b0;
		end else if (b == CH_HASH) begin
			r.in_comment = 1'b1;
		end else if (!is_ws(b)) begin
			r.trailing = 1'b1;
		end
		return r;
	endfunction

	function automatic put_t put_fn(input state_t s, input logic [15:0] v);
		put_t p;
		logic [15:0] col1;
		p.s = s;
		p.ok = (v <= s.maxval);
		p.col = s.col;
		p.row = s.height - s.row - 16'd1;
		col1 = s.col + 16'd1;
		if (p.ok) begin
			if (col1 >= s.width) begin
				p.s.col = 16'd0;
				p.s.row = s.row + 16'd1;
				if (p.s.row >= s.height) begin
					p.s.phase = PH_TRAIL;
					p.s.in_comment = 1'b0;
				end
			end else begin
				p.s.col = col1;
			end
		end
		return p;
	endfunction

	state_t st_q;
	state_t st_n;
	result_beat_t ra;
	result_beat_t rf;
	logic has_a;
	logic has_f;

	always_comb begin
		logic [7:0] b;
		logic eof;
		err_e err;
		idle_t id;
		put_t pp;
		logic [19:0] a20;
		logic [19:0] acc20;
		logic [19:0] lim;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] m;

		b = beat.byte_value;
		eof = beat.end_of_file;
		err = ERR_NONE;
		st_n = st_q;
		ra = '0;
		rf = '0;
		has_a = 1'b0;
		has_f = 1'b0;
		id = '0;
		pp = '0;
		w = st_q.width;
		h = st_q.height;
		m = st_q.maxval;
		a20 = {4'd0, st_q.acc};
		acc20 = (a20 << 3) + (a20 << 1) + {4'd0, digit_of(b)};
		lim = (st_q.phase == PH_HDR_M) ? SAMPLE_MAX : COORD_MAX;

		if (!go) begin
			st_n = st_q;
		end else if (st_q.err_latched) begin
			if (eof)
				st_n = ST_RESET;
		end else begin
			case (st_q.phase)
				PH_MAGIC_P: begin
					if (b == CH_P)
						st_n.phase = PH_MAGIC_D;
					else
						err = ERR_BAD_MAGIC;
				end
				PH_MAGIC_D: begin
					if (b == CH_2) begin
						st_n.binary_format = 1'b0;
						st_n.phase = PH_HDR_W;
					end else if (b == CH_5) begin
						st_n.binary_format = 1'b1;
						st_n.phase = PH_HDR_W;
					end else begin
						err = ERR_BAD_MAGIC;
					end
				end
				PH_HDR_W, PH_HDR_H, PH_HDR_M: begin
					if (!st_q.digit_seen) begin
						id = hdr_idle(st_q, b);
						st_n = id.s;
						err = id.err;
					end else if (is_digit(b)) begin
						st_n.acc = acc20[15:0];
						if (acc20 > lim)
							err = ERR_OVERFLOW;
					end else begin
						st_n.digit_seen = 1'b0;
						if (st_q.phase == PH_HDR_W) begin
							st_n.width = st_q.acc;
							st_n.phase = PH_HDR_H;
							id = hdr_idle(st_n, b);
							st_n = id.s;
							err = id.err;
						end else if (st_q.phase == PH_HDR_H) begin
							st_n.height = st_q.acc;
							st_n.phase = PH_HDR_M;
							id = hdr_idle(st_n, b);
							st_n = id.s;
							err = id.err;
						end else if (!is_ws(b)) begin
							err = ERR_NO_SEP;
						end else begin
							st_n.maxval = st_q.acc;
							st_n.two_byte = (st_q.acc >= TWO_BYTE_MIN);
							st_n.col = 16'd0;
							st_n.row = 16'd0;
							st_n.in_comment = 1'b0;
							st_n.phase = (st_q.width == 16'd0 || st_q.height == 16'd0) ?
								PH_TRAIL : PH_PIX;
							ra.kind = KIND_HEADER;
							has_a = 1'b1;
						end
					end
				end
				PH_PIX: begin
					if (st_q.binary_format) begin
						if (!st_q.two_byte) begin
							pp = put_fn(st_q, {8'd0, b});
							has_a = pp.ok;
						end else if (!st_q.high_held) begin
							st_n.high_byte = b;
							st_n.high_held = 1'b1;
						end else begin
							st_n.high_held = 1'b0;
							pp = put_fn(st_n, {st_q.high_byte, b});
							has_a = pp.ok;
						end
						if (has_a) begin
							st_n = pp.s;
							ra.kind = KIND_PIXEL;
							ra.pixel_value = st_q.two_byte ? {st_q.high_byte, b} : {8'd0, b};
							ra.column = pp.col;
							ra.row = pp.row;
						end else if (!st_q.two_byte || st_q.high_held) begin
							err = ERR_ABOVE_MAX;
						end
					end else if (!st_q.digit_seen) begin
						id = pix_idle(st_q, b);
						st_n = id.s;
						err = id.err;
					end else if (is_digit(b)) begin
						st_n.acc = acc20[15:0];
						if (acc20 > SAMPLE_MAX)
							err = ERR_OVERFLOW;
					end else begin
						st_n.digit_seen = 1'b0;
						pp = put_fn(st_n, st_q.acc);
						if (!pp.ok) begin
							err = ERR_ABOVE_MAX;
						end else begin
							st_n = pp.s;
							has_a = 1'b1;
							ra.kind = KIND_PIXEL;
							ra.pixel_value = st_q.acc;
							ra.column = pp.col;
							ra.row = pp.row;
							if (st_n.phase == PH_PIX) begin
								id = pix_idle(st_n, b);
								st_n = id.s;
								err = id.err;
							end else begin
								st_n = trail_fn(st_n, b);
							end
						end
					end
				end
				default: begin
					st_n = trail_fn(st_q, b);
				end
			endcase

			// a P2 value still open at end of file
			if (err == ERR_NONE && eof && st_n.phase == PH_PIX && !st_n.binary_format &&
				st_n.digit_seen) begin
				st_n.digit_seen = 1'b0;
				pp = put_fn(st_n, st_n.acc);
				if (!pp.ok) begin
					err = ERR_ABOVE_MAX;
				end else begin
					has_a = 1'b1;
					ra.kind = KIND_PIXEL;
					ra.pixel_value = st_n.acc;
					ra.column = pp.col;
					ra.row = pp.row;
					st_n = pp.s;
				end
			end

			w = st_n.width;
			h = st_n.height;
			m = st_n.maxval;

			if (err != ERR_NONE) begin
				has_f = 1'b1;
				rf.kind = KIND_ERROR;
				rf.error_code = err;
				rf.last = 1'b1;
				if (eof)
					st_n = ST_RESET;
				else
					st_n.err_latched = 1'b1;
			end else if (eof) begin
				has_f = 1'b1;
				rf.last = 1'b1;
				if (st_n.phase == PH_TRAIL) begin
					rf.kind = KIND_DONE;
					rf.trailing_data = st_n.trailing;
				end else begin
					rf.kind = KIND_ERROR;
					rf.error_code = ERR_TRUNCATED;
				end
				st_n = ST_RESET;
			end

			ra.image_width = w;
			ra.image_height = h;
			ra.max_value = m;
			rf.image_width = w;
			rf.image_height = h;
			rf.max_value = m;
		end
	end

	always_comb begin
		res_count = {1'b0, has_a} + {1'b0, has_f};
		res0 = has_a ? ra : rf;
		res1 = rf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else begin
			st_q <= st_n;
		end
	end

endmodule

`default_nettype wire

### hdl/psp_result_fifo.sv
// psp_result_fifo: small result queue, takes up to two beats per cycle, gives one when not stalled.
// Decouples the parser from a stalling receiver.
// Depends on psp_pkg.
`default_nettype none

module psp_result_fifo import psp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [1:0] push_count,
	input wire result_beat_t push0,
	input wire result_beat_t push1,
	output logic room,
	output logic out_valid,
	input wire logic out_stall,
	output result_beat_t out_beat
);

	result_beat_t entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0] count_q;
	logic pop;
	logic [FIFO_AW-1:0] wr_ptr1;

	assign room = (count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_beat = entry_q[rd_ptr_q];
	assign pop = out_valid && !out_stall;
	assign wr_ptr1 = wr_ptr_q + FIFO_AW'(1);

	always_ff @(posedge clk) begin
		if (push_count != 2'd0)
			entry_q[wr_ptr_q] <= push0;
		if (push_count == 2'd2)
			entry_q[wr_ptr1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + (FIFO_AW + 1)'(push_count) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

`default_nettype wire

### hdl/pgm_stream_parser.sv
// pgm_stream_parser: PGM (P2/P5) byte stream decoder, top level.
// Input register, parser step logic, result queue.
// Depends on psp_pkg, psp_parser, psp_result_fifo.
//
// Usage:
//   stream_*  one file byte per beat, end_of_file set on the last byte.
//   result_*  pixel, header, error and finished beats, last set on the beat
//             that closes a file.
//   A byte is parsed while it sits in the input register; its results are
//   written into the result queue and leave from there.
//   One byte is taken per cycle while the queue has room. A byte that makes
//   two results (a pixel and the closing beat) hands them out one by one; the
//   4-entry result queue absorbs this and stream_stall rises only when fewer
//   than two queue slots are free while a byte waits in the input register.
//   When the receiver stalls, result beats stay queued and the input backs up.
//   Reset clears the parse state, the input register and the queue; the block
//   then expects the magic of a new file.
`default_nettype none

module pgm_stream_parser import psp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic stream_valid,
	output logic stream_stall,
	input wire stream_beat_t stream_beat,
	output logic result_valid,
	input wire logic result_stall,
	output result_beat_t result_beat
);

	logic valid_s1;
	stream_beat_t beat_s1;
	logic room;
	logic go;
	logic [1:0] res_count;
	result_beat_t res0;
	result_beat_t res1;

	assign go = valid_s1 && room;
	assign stream_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stream_stall) begin
			valid_s1 <= stream_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stream_stall && stream_valid)
			beat_s1 <= stream_beat;
	end

	psp_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.beat(beat_s1),
		.res_count(res_count),
		.res0(res0),
		.res1(res1)
	);

	psp_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_count(res_count),
		.push0(res0),
		.push1(res1),
		.room(room),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.out_beat(result_beat)
	);

	a_two_only_closing: assert property (@(posedge clk) disable iff (!arst_n)
		res_count == 2'd2 |-> (res1.last && !res0.last))
		else $error("second result of a byte is not the closing beat");

	a_idle_no_results: assert property (@(posedge clk) disable iff (!arst_n)
		!go |-> res_count == 2'd0)
		else $error("results produced without a byte");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_count != 2'd0 |=> result_valid)
		else $error("pushed result not visible");

	a_pixel_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_beat.kind == KIND_PIXEL |->
			(result_beat.error_code == ERR_NONE && !result_beat.last))
		else $error("pixel beat carries error or last");

endmodule

`default_nettype wire
